// ===== design/tlc_pkg.sv =====
// shared types, character codes and decode helpers for the two-line element line checker
`default_nettype none

package tlc_pkg;

	// default column of the check digit
	localparam int CHECK_COLUMN_DEF = 68;

	// catalog number field columns
	localparam int FIELD_FIRST = 2;
	localparam int FIELD_LAST  = 6;

	// weight of the alpha-5 leading letter
	localparam int ALPHA_SCALE = 10000;

	// field widths
	localparam int CHAR_W    = 8;
	localparam int SUM_W     = 4;
	localparam int HIGH_W    = 6;
	localparam int ACCUM_W   = 17;
	localparam int CATALOG_W = 19;

	// character codes
	localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CHR_NINE    = 8'd57;
	localparam logic [CHAR_W-1:0] CHR_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] CHR_MINUS   = 8'd45;
	localparam logic [CHAR_W-1:0] CHR_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CHR_UPPER_H = 8'd72;
	localparam logic [CHAR_W-1:0] CHR_UPPER_J = 8'd74;
	localparam logic [CHAR_W-1:0] CHR_UPPER_N = 8'd78;
	localparam logic [CHAR_W-1:0] CHR_UPPER_P = 8'd80;
	localparam logic [CHAR_W-1:0] CHR_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] CHR_LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] CHR_LOWER_Z = 8'd122;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

	// alpha-5 leader values of the first letter in each run
	localparam logic [HIGH_W-1:0] HIGH_A = 6'd10;
	localparam logic [HIGH_W-1:0] HIGH_J = 6'd18;
	localparam logic [HIGH_W-1:0] HIGH_P = 6'd23;

	// catalog field scan phase
	typedef enum logic [1:0] {
		PH_LEAD  = 2'd0,
		PH_BODY  = 2'd1,
		PH_TRAIL = 2'd2
	} phase_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CHR_ZERO) && (c <= CHR_NINE);
	endfunction

	function automatic logic is_letter(input logic [CHAR_W-1:0] c);
		return ((c >= CHR_UPPER_A) && (c <= CHR_UPPER_Z)) ||
			((c >= CHR_LOWER_A) && (c <= CHR_LOWER_Z));
	endfunction

	// alpha-5 leader value 10..33, zero for I, O or a non-letter
	function automatic logic [HIGH_W-1:0] leader_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] u;
		u = c;
		if ((c >= CHR_LOWER_A) && (c <= CHR_LOWER_Z)) begin
			u = c - CASE_OFFSET;
		end
		if ((u >= CHR_UPPER_A) && (u <= CHR_UPPER_H)) begin
			return HIGH_A + HIGH_W'(u - CHR_UPPER_A);
		end
		if ((u >= CHR_UPPER_J) && (u <= CHR_UPPER_N)) begin
			return HIGH_J + HIGH_W'(u - CHR_UPPER_J);
		end
		if ((u >= CHR_UPPER_P) && (u <= CHR_UPPER_Z)) begin
			return HIGH_P + HIGH_W'(u - CHR_UPPER_P);
		end
		return '0;
	endfunction

endpackage

`default_nettype wire

// ===== design/tle_line_checker.sv =====
// top level of the two-line element line checker
//
// Usage:
// The char channel (char_valid, char_stall, char_code, end_of_line) takes one
// character of an element line per item, in column order; end_of_line marks
// the line's last character. The result channel (result_valid, result_stall
// and the result fields) gives one item per line, on the line's last
// character: computed and stated checksums, match and length flags, and the
// decoded catalog number with its valid flag. Lines without a last-character
// mark give no result.
// A taken character lands in the input register; its result, if any, is then
// registered in the result register.
// Throughput: one character per cycle while no waiting result is stalled; each
// character updates the running sum, column counter and catalog field registers.
// Reset clears both channels and all line state. When the receiver stalls a
// waiting result, the input register holds its character and char_stall
// rises once that register is full; nothing is lost or repeated.
`default_nettype none

module tle_line_checker #(
	parameter int CHECK_COLUMN = tlc_pkg::CHECK_COLUMN_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire logic [tlc_pkg::CHAR_W-1:0]    char_code,
	input  wire logic                          end_of_line,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic [tlc_pkg::SUM_W-1:0]          computed_checksum,
	output logic [tlc_pkg::SUM_W-1:0]          stated_checksum,
	output logic                               checksum_ok,
	output logic                               length_ok,
	output logic [tlc_pkg::CATALOG_W-1:0]      sat_number,
	output logic                               catalog_valid
);
	import tlc_pkg::*;

	localparam int COL_W = $clog2(CHECK_COLUMN + 2);
	localparam logic [COL_W-1:0] COL_CHECK = COL_W'(CHECK_COLUMN);
	localparam logic [COL_W-1:0] COL_FULL  = COL_W'(CHECK_COLUMN + 1);
	localparam logic [COL_W-1:0] COL_FIRST = COL_W'(FIELD_FIRST);
	localparam logic [COL_W-1:0] COL_LAST  = COL_W'(FIELD_LAST);
	localparam logic [COL_W-1:0] COL_AFTER = COL_W'(FIELD_LAST + 1);
	localparam logic [SUM_W-1:0] SUM_MOD   = SUM_W'(10);
	localparam logic [ACCUM_W-1:0] ACCUM_TEN = ACCUM_W'(10);
	localparam logic [CATALOG_W-1:0] SCALE = CATALOG_W'(ALPHA_SCALE);

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              eol_s1;
	logic              advance;

	// line state
	logic [COL_W-1:0]   column_count_q;
	logic [SUM_W-1:0]   running_sum_q;
	logic [SUM_W-1:0]   check_digit_q;
	logic               check_seen_q;
	logic [HIGH_W-1:0]  alpha_high_q;
	logic [ACCUM_W-1:0] digit_accum_q;
	phase_t             field_phase_q;
	logic               field_bad_q;

	// next line state
	logic [COL_W-1:0]   column_count_d;
	logic [SUM_W-1:0]   running_sum_d;
	logic [SUM_W-1:0]   check_digit_d;
	logic               check_seen_d;
	logic [HIGH_W-1:0]  alpha_high_d;
	logic [ACCUM_W-1:0] digit_accum_d;
	phase_t             field_phase_d;
	logic               field_bad_d;

	// result register
	logic                 result_valid_q;
	logic [SUM_W-1:0]     computed_q;
	logic [SUM_W-1:0]     stated_q;
	logic                 checksum_ok_q;
	logic                 length_ok_q;
	logic [CATALOG_W-1:0] catalog_q;
	logic                 catalog_valid_q;

	// result values of the current character
	logic                 len_ok;
	logic                 cs_ok;
	logic                 cat_ok;
	logic [CATALOG_W-1:0] cat_value;
	logic [SUM_W-1:0]     add_value;
	logic [SUM_W:0]       sum_wide;
	logic [SUM_W-1:0]     char_digit;
	logic                 char_is_digit;

	// the input register moves on whenever the result register can take a result
	assign advance    = !result_valid_q || !result_stall;
	assign char_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!char_stall) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && !char_stall) begin
			char_s1 <= char_code;
			eol_s1  <= end_of_line;
		end
	end

	// per-character update of the line state
	always_comb begin
		char_is_digit = is_digit(char_s1);
		char_digit    = SUM_W'(char_s1 - CHR_ZERO);

		column_count_d = column_count_q;
		running_sum_d  = running_sum_q;
		check_digit_d  = check_digit_q;
		check_seen_d   = check_seen_q;
		alpha_high_d   = alpha_high_q;
		digit_accum_d  = digit_accum_q;
		field_phase_d  = field_phase_q;
		field_bad_d    = field_bad_q;

		// checksum over the columns before the check column
		add_value = '0;
		if (char_is_digit) begin
			add_value = char_digit;
		end else if (char_s1 == CHR_MINUS) begin
			add_value = SUM_W'(1);
		end
		sum_wide = {1'b0, running_sum_q} + {1'b0, add_value};
		if (column_count_q < COL_CHECK) begin
			running_sum_d = (sum_wide >= {1'b0, SUM_MOD}) ?
				SUM_W'(sum_wide - {1'b0, SUM_MOD}) : SUM_W'(sum_wide);
		end else if (column_count_q == COL_CHECK) begin
			check_digit_d = char_is_digit ? char_digit : '0;
			check_seen_d  = char_is_digit;
		end

		// catalog number field scan
		if ((column_count_q >= COL_FIRST) && (column_count_q <= COL_LAST)) begin
			unique case (field_phase_q)
				PH_LEAD: begin
					if (char_s1 != CHR_SPACE) begin
						field_phase_d = PH_BODY;
						if (char_is_digit) begin
							digit_accum_d = ACCUM_W'(char_digit);
						end else if (is_letter(char_s1)) begin
							if (leader_value(char_s1) == '0) begin
								field_bad_d = 1'b1;
							end else begin
								alpha_high_d = leader_value(char_s1);
							end
						end else begin
							field_bad_d = 1'b1;
						end
					end
				end
				PH_BODY: begin
					if (char_is_digit) begin
						digit_accum_d = digit_accum_q * ACCUM_TEN + ACCUM_W'(char_digit);
					end else if (char_s1 == CHR_SPACE) begin
						field_phase_d = PH_TRAIL;
					end else begin
						field_bad_d = 1'b1;
					end
				end
				default: begin
					if (char_s1 != CHR_SPACE) begin
						field_bad_d   = 1'b1;
						field_phase_d = PH_BODY;
					end
				end
			endcase
		end

		// saturating column counter
		if (column_count_q < COL_FULL) begin
			column_count_d = column_count_q + COL_W'(1);
		end

		// line-end summary
		len_ok    = column_count_d >= COL_FULL;
		cs_ok     = len_ok && check_seen_d && (running_sum_d == check_digit_d);
		cat_ok    = (column_count_d >= COL_AFTER) && (field_phase_d != PH_LEAD) && !field_bad_d;
		cat_value = cat_ok ? (CATALOG_W'(alpha_high_d) * SCALE + CATALOG_W'(digit_accum_d)) : '0;
	end

	// line state registers, cleared after each line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			running_sum_q  <= '0;
			check_digit_q  <= '0;
			check_seen_q   <= 1'b0;
			alpha_high_q   <= '0;
			digit_accum_q  <= '0;
			field_phase_q  <= PH_LEAD;
			field_bad_q    <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (eol_s1) begin
				column_count_q <= '0;
				running_sum_q  <= '0;
				check_digit_q  <= '0;
				check_seen_q   <= 1'b0;
				alpha_high_q   <= '0;
				digit_accum_q  <= '0;
				field_phase_q  <= PH_LEAD;
				field_bad_q    <= 1'b0;
			end else begin
				column_count_q <= column_count_d;
				running_sum_q  <= running_sum_d;
				check_digit_q  <= check_digit_d;
				check_seen_q   <= check_seen_d;
				alpha_high_q   <= alpha_high_d;
				digit_accum_q  <= digit_accum_d;
				field_phase_q  <= field_phase_d;
				field_bad_q    <= field_bad_d;
			end
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1 && eol_s1;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && eol_s1) begin
			computed_q      <= running_sum_d;
			stated_q        <= check_seen_d ? check_digit_d : '0;
			checksum_ok_q   <= cs_ok;
			length_ok_q     <= len_ok;
			catalog_q       <= cat_value;
			catalog_valid_q <= cat_ok;
		end
	end

	assign result_valid      = result_valid_q;
	assign computed_checksum = computed_q;
	assign stated_checksum   = stated_q;
	assign checksum_ok       = checksum_ok_q;
	assign length_ok         = length_ok_q;
	assign sat_number        = catalog_q;
	assign catalog_valid     = catalog_valid_q;

`ifndef SYNTHESIS
	// a matching checksum needs a full line and equal sums
	a_cs_ok_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && checksum_ok_q |-> length_ok_q && (computed_q == stated_q))
		else $error("checksum_ok without full line or matching sums");

	// an invalid catalog field reads as zero
	a_cat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !catalog_valid_q |-> catalog_q == '0)
		else $error("invalid catalog field with nonzero number");

	// running sum stays a decimal digit
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		running_sum_q < SUM_MOD)
		else $error("running sum out of range");

	// column counter never passes saturation
	a_col_sat: assert property (@(posedge clk) disable iff (!arst_n)
		column_count_q <= COL_FULL)
		else $error("column counter past saturation");

	// input is held back only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> result_valid_q && result_stall && valid_s1)
		else $error("input stalled without a waiting result");
`endif

endmodule

`default_nettype wire

// ===== verif/tle_line_checker_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for tle_line_checker: directed and random element lines against a predictor

module tle_line_checker_test;
	import tlc_pkg::*;

	localparam int CHECK_COL   = CHECK_COLUMN_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int QUIET_FROM  = 300;
	localparam int QUIET_TO    = 800;
	localparam int FIELD_LINE  = FIELD_LAST + 6;

	localparam logic [CHAR_W-1:0] CHR_UPPER_I = 8'd73;
	localparam logic [CHAR_W-1:0] CHR_UPPER_O = 8'd79;
	localparam logic [CHAR_W-1:0] CHR_DOT     = 8'd46;
	localparam logic [CHAR_W-1:0] CHR_PLUS    = 8'd43;

	// what a generated line carries in its check column
	typedef enum int {CHK_GOOD, CHK_WRONG, CHK_NONDIGIT, CHK_NOISE} check_mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] code;
		logic              last;
		logic              hold;
	} line_char_t;

	typedef struct packed {
		logic [SUM_W-1:0]     computed;
		logic [SUM_W-1:0]     stated;
		logic                 sum_match;
		logic                 long_enough;
		logic [CATALOG_W-1:0] catalog;
		logic                 catalog_good;
	} line_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	logic [CHAR_W-1:0] char_code = '0;
	logic end_of_line = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [SUM_W-1:0] computed_checksum;
	logic [SUM_W-1:0] stated_checksum;
	logic checksum_ok;
	logic length_ok;
	logic [CATALOG_W-1:0] sat_number;
	logic catalog_valid;

	line_char_t pending_chars[$];
	line_report_t line_reports[$];
	int cycles = 0;
	int errors = 0;

	// predictor state for the line in progress
	logic [6:0]         col_seen = '0;
	logic [SUM_W-1:0]   sum_mod10 = '0;
	logic [SUM_W-1:0]   check_val = '0;
	logic               check_found = 1'b0;
	logic [HIGH_W-1:0]  lead_high = '0;
	logic [ACCUM_W-1:0] field_value = '0;
	phase_t             scan_phase = PH_LEAD;
	logic               field_broken = 1'b0;

	tle_line_checker #(
		.CHECK_COLUMN(CHECK_COL)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_code(char_code),
		.end_of_line(end_of_line),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.computed_checksum(computed_checksum),
		.stated_checksum(stated_checksum),
		.checksum_ok(checksum_ok),
		.length_ok(length_ok),
		.sat_number(sat_number),
		.catalog_valid(catalog_valid)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// random gaps, none inside the quiet window
	function automatic bit idle_roll();
		return !(cycles >= QUIET_FROM && cycles < QUIET_TO) && ($urandom_range(0, 99) < 20);
	endfunction

	// advance the line state by one accepted character, queue the report at line end
	task automatic track_char(input logic [CHAR_W-1:0] c, input logic eol);
		logic is_num;
		logic [3:0] dval;
		logic [CHAR_W-1:0] up;
		logic [HIGH_W-1:0] rank;
		logic field_ok;
		line_report_t rep;
		is_num = (c >= CHR_ZERO) && (c <= CHR_NINE);
		dval = 4'(c - CHR_ZERO);
		up = ((c >= CHR_LOWER_A) && (c <= CHR_LOWER_Z)) ? c - CASE_OFFSET : c;
		rank = '0;
		if (up >= CHR_UPPER_A && up <= CHR_UPPER_Z && up != CHR_UPPER_I && up != CHR_UPPER_O) begin
			rank = HIGH_A + HIGH_W'(up - CHR_UPPER_A) - HIGH_W'(up > CHR_UPPER_I)
				- HIGH_W'(up > CHR_UPPER_O);
		end

		// checksum columns and the check column
		if (col_seen < CHECK_COL) begin
			if (is_num) begin
				sum_mod10 = SUM_W'((sum_mod10 + dval) % 10);
			end else if (c == CHR_MINUS) begin
				sum_mod10 = SUM_W'((sum_mod10 + 1) % 10);
			end
		end else if (col_seen == CHECK_COL) begin
			check_found = is_num;
			check_val = is_num ? dval : '0;
		end

		// catalog field scan
		if (col_seen >= FIELD_FIRST && col_seen <= FIELD_LAST) begin
			case (scan_phase)
				PH_LEAD: begin
					if (c != CHR_SPACE) begin
						scan_phase = PH_BODY;
						if (is_num) field_value = ACCUM_W'(dval);
						else if (rank != 0) lead_high = rank;
						else field_broken = 1'b1;
					end
				end
				PH_BODY: begin
					if (is_num) field_value = ACCUM_W'(field_value * 10 + dval);
					else if (c == CHR_SPACE) scan_phase = PH_TRAIL;
					else field_broken = 1'b1;
				end
				default: begin
					if (c != CHR_SPACE) begin
						field_broken = 1'b1;
						scan_phase = PH_BODY;
					end
				end
			endcase
		end
		if (col_seen < CHECK_COL + 1) col_seen = col_seen + 1;

		// line end: report and start over
		if (eol) begin
			field_ok = (col_seen >= FIELD_LAST + 1) && (scan_phase != PH_LEAD) && !field_broken;
			rep.computed = sum_mod10;
			rep.stated = check_found ? check_val : '0;
			rep.long_enough = col_seen >= CHECK_COL + 1;
			rep.sum_match = rep.long_enough && check_found && (sum_mod10 == check_val);
			rep.catalog = field_ok ? CATALOG_W'(lead_high * ALPHA_SCALE + field_value) : '0;
			rep.catalog_good = field_ok;
			line_reports.push_back(rep);
			col_seen = '0;
			sum_mod10 = '0;
			check_val = '0;
			check_found = 1'b0;
			lead_high = '0;
			field_value = '0;
			scan_phase = PH_LEAD;
			field_broken = 1'b0;
		end
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// queue one line: field holds columns 2..6, first column in the top byte
	task automatic send_line(input logic [39:0] field, input int line_len,
			input check_mode_t mode, input bit pause);
		logic [CHAR_W-1:0] ch;
		line_char_t item;
		int sum;
		int pick;
		sum = 0;
		for (int col = 0; col < line_len; col++) begin
			pick = $urandom_range(0, 99);
			if (col >= FIELD_FIRST && col <= FIELD_LAST) begin
				ch = field[8*(FIELD_LAST-col) +: 8];
			end else if (mode == CHK_NOISE) begin
				ch = 8'($urandom_range(0, 255));
			end else if (col == 0) begin
				ch = CHR_ZERO + 8'($urandom_range(1, 2));
			end else if (col == 1) begin
				ch = CHR_SPACE;
			end else if (col == CHECK_COL) begin
				if (mode == CHK_GOOD) begin
					ch = CHR_ZERO + 8'(sum % 10);
				end else if (mode == CHK_WRONG) begin
					ch = CHR_ZERO + 8'((sum + $urandom_range(1, 9)) % 10);
				end else begin
					ch = CHR_ZERO;
					while (ch >= CHR_ZERO && ch <= CHR_NINE) ch = 8'($urandom_range(0, 255));
				end
			end else if (pick < 50) begin
				ch = CHR_ZERO + 8'($urandom_range(0, 9));
			end else if (pick < 70) begin
				ch = CHR_SPACE;
			end else if (pick < 80) begin
				ch = CHR_MINUS;
			end else if (pick < 88) begin
				ch = CHR_DOT;
			end else if (pick < 92) begin
				ch = CHR_PLUS;
			end else begin
				ch = CHR_UPPER_A + 8'($urandom_range(0, 25));
			end
			if (col < CHECK_COL) begin
				if (ch >= CHR_ZERO && ch <= CHR_NINE) sum += ch - CHR_ZERO;
				else if (ch == CHR_MINUS) sum += 1;
			end
			item.code = ch;
			item.last = (col == line_len - 1);
			item.hold = pause && (col == 0);
			pending_chars.push_back(item);
		end
	endtask

	// cycle count and run timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tle_line_checker_test failed");
			$finish;
		end
	end

	// character driver: predict on acceptance, then offer the next item
	always @(posedge clk) begin : char_driver
		line_char_t nxt;
		logic offer;
		if (arst_n) begin
			if (char_valid && !char_stall) track_char(char_code, end_of_line);
			if (!char_valid || !char_stall) begin
				offer = (pending_chars.size() != 0) && !idle_roll();
				if (offer && pending_chars[0].hold && line_reports.size() != 0) offer = 1'b0;
				if (offer) begin
					nxt = pending_chars.pop_front();
					char_code <= nxt.code;
					end_of_line <= nxt.last;
				end
				char_valid <= offer;
			end
		end
	end

	// result monitor: compare each accepted item with the oldest line report
	always @(posedge clk) begin : result_monitor
		line_report_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (line_reports.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, got catalog %0d sum %0d",
						$time, sat_number, computed_checksum);
				end else begin
					want = line_reports.pop_front();
					compare_field("computed_checksum", want.computed, computed_checksum);
					compare_field("stated_checksum", want.stated, stated_checksum);
					compare_field("checksum_ok", want.sum_match, checksum_ok);
					compare_field("length_ok", want.long_enough, length_ok);
					compare_field("sat_number", want.catalog, sat_number);
					compare_field("catalog_valid", want.catalog_good, catalog_valid);
				end
			end
			result_stall <= idle_roll();
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [39:0] fld;
		logic [CHAR_W-1:0] lead;
		int kind;
		int pick;
		int len;
		int n;
		int lines;
		check_mode_t mode;

		// directed lines
		send_line("25544", CHECK_COL + 1, CHK_GOOD, 1'b0);
		send_line("A0001", CHECK_COL + 1, CHK_GOOD, 1'b0);
		send_line("z9999", CHECK_COL + 2, CHK_GOOD, 1'b0);
		send_line("j0000", CHECK_COL + 1, CHK_GOOD, 1'b0);
		send_line("00000", CHECK_COL + 1, CHK_WRONG, 1'b0);
		send_line("12345", CHECK_COL + 1, CHK_NONDIGIT, 1'b0);
		send_line("99999", 4, CHK_GOOD, 1'b0);
		send_line("99999", FIELD_LAST + 1, CHK_GOOD, 1'b0);
		send_line("31337", CHECK_COL, CHK_GOOD, 1'b0);
		send_line("31337", CHECK_COL + 8, CHK_GOOD, 1'b0);
		send_line("1 2 3", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("12A34", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("I1234", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("o9999", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("     ", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("  123", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("123  ", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("  Z  ", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("-1234", FIELD_LINE, CHK_GOOD, 1'b0);
		send_line({"12", 8'hFF, "45"}, FIELD_LINE, CHK_GOOD, 1'b0);
		send_line({8'h00, "2345"}, FIELD_LINE, CHK_GOOD, 1'b0);
		send_line("00000", 1, CHK_GOOD, 1'b0);
		send_line("77777", 80, CHK_NOISE, 1'b0);

		// random lines, mostly well formed with random content
		lines = 0;
		while (pending_chars.size() < 1200) begin
			kind = $urandom_range(0, 99);
			n = $urandom_range(1, 4);
			for (int i = 0; i < 5; i++) fld[8*i +: 8] = CHR_ZERO + 8'($urandom_range(0, 9));
			lead = CHR_UPPER_I;
			while (lead == CHR_UPPER_I || lead == CHR_UPPER_O) begin
				lead = CHR_UPPER_A + 8'($urandom_range(0, 25));
			end
			if ($urandom_range(0, 2) == 0) lead = lead + CASE_OFFSET;
			if (kind < 25) begin
				fld[39:32] = lead;
			end else if (kind < 33) begin
				for (int i = 0; i < n; i++) fld[39-8*i -: 8] = CHR_SPACE;
			end else if (kind < 39) begin
				for (int i = 0; i < n; i++) fld[8*i +: 8] = CHR_SPACE;
			end else if (kind < 43) begin
				fld = {5{CHR_SPACE}};
				fld[8*(4-n) +: 8] = lead;
			end else if (kind < 46) begin
				fld = {5{CHR_SPACE}};
			end else if (kind < 50) begin
				fld[8*$urandom_range(1, 3) +: 8] = CHR_SPACE;
			end else if (kind < 53) begin
				fld[39:32] = ($urandom_range(0, 1) ? CHR_UPPER_I : CHR_UPPER_O)
					+ ($urandom_range(0, 1) ? CASE_OFFSET : 8'd0);
			end else if (kind < 57) begin
				fld[8*(4-n) +: 8] = lead;
			end else if (kind < 62) begin
				fld[8*$urandom_range(0, 4) +: 8] = 8'($urandom_range(0, 255));
			end

			pick = $urandom_range(0, 99);
			if (pick < 45) len = CHECK_COL + 1;
			else if (pick < 60) len = $urandom_range(CHECK_COL + 2, CHECK_COL + 12);
			else if (pick < 80) len = $urandom_range(FIELD_LAST + 2, CHECK_COL);
			else len = $urandom_range(1, FIELD_LAST + 1);

			pick = $urandom_range(0, 99);
			if (pick < 80) mode = CHK_GOOD;
			else if (pick < 88) mode = CHK_WRONG;
			else if (pick < 95) mode = CHK_NONDIGIT;
			else mode = CHK_NOISE;

			// the first random line waits for the directed results to drain
			send_line(fld, len, mode, (lines == 0) || ($urandom_range(0, 19) == 0));
			lines++;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_chars.size() != 0 || char_valid) @(posedge clk);
		while (line_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		if (errors == 0) begin
			$display("tle_line_checker_test passed");
		end else begin
			$display("tle_line_checker_test failed");
		end
		$finish;
	end

endmodule
